### sv/frame_bitmap_allocator_defines.svh
// ----------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Shared concurrent assertion forms for the checker on clk, with arst_n reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/fba_pkg.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Field widths, request codes and the result record shared by the block.
// ----------------------------------------------------------------------------
package fba_pkg;

	// Default geometry
	localparam int FRAME_COUNT_DEF = 65536;
	localparam int WORD_BITS_DEF   = 32;

	// Stream field widths
	localparam int FRAME_W    = 16;
	localparam int COUNT_W    = 17;
	localparam int MODE_W     = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;

	// Request kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_TEST    = 2'd0,
		MODE_MARK    = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_FIND    = 2'd3
	} mode_t;

	// Result record, found_frame in the lowest bits
	typedef struct packed {
		logic [COUNT_W-1:0] free_total;
		logic               frame_used;
		logic               found;
		logic [FRAME_W-1:0] found_frame;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

### sv/fba_ram.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fba_ram #(
	parameter int DEPTH = fba_pkg::FRAME_COUNT_DEF / fba_pkg::WORD_BITS_DEF,
	parameter int WIDTH = fba_pkg::WORD_BITS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and read port; read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/fba_seq.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator sequencer
// Owns the bitmap and word-full summary RAMs, the top-level full flags and
// the free counter; runs clear, read-modify-write and search sequences.
// ----------------------------------------------------------------------------
module fba_seq #(
	parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEF,
	parameter int WORD_BITS   = fba_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  fba_pkg::mode_t                  in_mode,
	input  logic [fba_pkg::FRAME_W-1:0]     in_frame,
	output logic                            res_valid,
	output fba_pkg::result_t                res,
	input  logic                            res_room
);

	// Geometry (WORD_BITS is a power of two)
	localparam int WORDS     = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int SUM_WORDS = (WORDS + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SIDX_W    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
	localparam int CNT_W     = $clog2(FRAME_COUNT + 1);
	localparam int FRM_W     = WIDX_W + BIT_W;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_UPD   = 6'b000100,
		S_FSUM  = 6'b001000,
		S_FWORD = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	// Bits past the last frame count as used
	function automatic logic [WORD_BITS-1:0] word_pad(input logic [WIDX_W-1:0] w);
		logic [WORD_BITS-1:0] p;
		p = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			p[b] = (int'(w) * WORD_BITS + b) >= FRAME_COUNT;
		end
		return p;
	endfunction

	// Summary bits past the last bitmap word count as full
	function automatic logic [WORD_BITS-1:0] sum_pad(input logic [SIDX_W-1:0] s);
		logic [WORD_BITS-1:0] p;
		p = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			p[b] = (int'(s) * WORD_BITS + b) >= WORDS;
		end
		return p;
	endfunction

	// Lowest clear bit of a word
	function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!v[b]) begin
				idx = BIT_W'(b);
			end
		end
		return idx;
	endfunction

	// Lowest summary word that is not full
	function automatic logic [SIDX_W-1:0] top_first_zero(input logic [SUM_WORDS-1:0] v);
		logic [SIDX_W-1:0] idx;
		idx = '0;
		for (int b = SUM_WORDS - 1; b >= 0; b--) begin
			if (!v[b]) begin
				idx = SIDX_W'(b);
			end
		end
		return idx;
	endfunction

	state_t                 state_q;
	logic [WIDX_W-1:0]      clr_q;
	logic [SUM_WORDS-1:0]   top_q;
	logic [CNT_W-1:0]       free_q;
	fba_pkg::mode_t         mode_q;
	logic [FRM_W-1:0]       frame_q;
	logic [SIDX_W-1:0]      si_q;

	logic                   bm_wr_en;
	logic [WIDX_W-1:0]      bm_wr_addr;
	logic [WORD_BITS-1:0]   bm_wr_data;
	logic                   bm_rd_en;
	logic [WIDX_W-1:0]      bm_rd_addr;
	logic [WORD_BITS-1:0]   bm_rd_data;
	logic                   sm_wr_en;
	logic [SIDX_W-1:0]      sm_wr_addr;
	logic [WORD_BITS-1:0]   sm_wr_data;
	logic                   sm_rd_en;
	logic [SIDX_W-1:0]      sm_rd_addr;
	logic [WORD_BITS-1:0]   sm_rd_data;

	logic [WIDX_W-1:0]      in_wi;
	logic                   in_ok;
	logic                   top_free;
	logic [SIDX_W-1:0]      top_si;
	logic [WIDX_W-1:0]      fz_wi;
	logic [WIDX_W-1:0]      wi_u;
	logic [BIT_W-1:0]       bit_u;
	logic                   used_u;
	logic                   set_u;
	logic                   rel_u;
	logic                   changed_u;
	logic [WORD_BITS-1:0]   new_word;
	logic                   full_u;
	logic [WORD_BITS-1:0]   sum_new;
	logic                   top_full_u;
	logic [BIT_W-1:0]       fb;
	logic [CNT_W-1:0]       free_next;

	fba_ram #(.DEPTH(WORDS), .WIDTH(WORD_BITS), .AW(WIDX_W)) u_bitmap (
		.clk     (clk),
		.wr_en   (bm_wr_en),
		.wr_addr (bm_wr_addr),
		.wr_data (bm_wr_data),
		.rd_en   (bm_rd_en),
		.rd_addr (bm_rd_addr),
		.rd_data (bm_rd_data)
	);

	fba_ram #(.DEPTH(SUM_WORDS), .WIDTH(WORD_BITS), .AW(SIDX_W)) u_summary (
		.clk     (clk),
		.wr_en   (sm_wr_en),
		.wr_addr (sm_wr_addr),
		.wr_data (sm_wr_data),
		.rd_en   (sm_rd_en),
		.rd_addr (sm_rd_addr),
		.rd_data (sm_rd_data)
	);

	// Request decode at accept
	assign in_wi    = WIDX_W'(32'(in_frame) >> BIT_W);
	assign in_ok    = 32'(in_frame) < 32'(FRAME_COUNT);
	assign top_free = ~&top_q;
	assign top_si   = top_first_zero(top_q);
	assign in_ready = (state_q == S_IDLE);

	// Search: free word within the chosen summary word
	assign fz_wi = WIDX_W'({si_q, first_zero(sm_rd_data | sum_pad(si_q))});

	// Read-modify-write of one frame bit and its summary bit
	assign wi_u       = frame_q[FRM_W-1:BIT_W];
	assign bit_u      = frame_q[BIT_W-1:0];
	assign used_u     = bm_rd_data[bit_u];
	assign set_u      = (mode_q == fba_pkg::MODE_MARK) && !used_u;
	assign rel_u      = (mode_q == fba_pkg::MODE_RELEASE) && used_u;
	assign changed_u  = set_u || rel_u;
	assign full_u     = &(new_word | word_pad(wi_u));
	assign top_full_u = &(sum_new | sum_pad(si_q));
	assign fb         = first_zero(bm_rd_data | word_pad(wi_u));

	always_comb begin
		new_word = bm_rd_data;
		if (set_u) begin
			new_word[bit_u] = 1'b1;
		end
		if (rel_u) begin
			new_word[bit_u] = 1'b0;
		end
		sum_new = sm_rd_data;
		sum_new[BIT_W'(wi_u)] = full_u;
	end

	// Saturating free count
	always_comb begin
		free_next = free_q;
		if (set_u && free_q != '0) begin
			free_next = free_q - CNT_W'(1);
		end else if (rel_u && free_q != CNT_W'(FRAME_COUNT)) begin
			free_next = free_q + CNT_W'(1);
		end
	end

	// RAM port control
	always_comb begin
		bm_wr_en   = 1'b0;
		bm_wr_addr = wi_u;
		bm_wr_data = new_word;
		bm_rd_en   = 1'b0;
		bm_rd_addr = in_wi;
		sm_wr_en   = 1'b0;
		sm_wr_addr = si_q;
		sm_wr_data = sum_new;
		sm_rd_en   = 1'b0;
		sm_rd_addr = SIDX_W'(in_wi >> BIT_W);
		unique case (state_q)
			S_CLEAR: begin
				bm_wr_en   = 1'b1;
				bm_wr_addr = clr_q;
				bm_wr_data = '0;
				sm_wr_en   = 32'(clr_q) < 32'(SUM_WORDS);
				sm_wr_addr = SIDX_W'(clr_q);
				sm_wr_data = '0;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (in_mode == fba_pkg::MODE_FIND) begin
						sm_rd_en   = top_free;
						sm_rd_addr = top_si;
					end else begin
						bm_rd_en = in_ok;
						sm_rd_en = in_ok;
					end
				end
			end
			S_FSUM: begin
				bm_rd_en   = 1'b1;
				bm_rd_addr = fz_wi;
			end
			S_UPD: begin
				bm_wr_en = res_room && changed_u;
				sm_wr_en = res_room && changed_u;
			end
			S_FWORD, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Result build
	always_comb begin
		res_valid       = 1'b0;
		res.found_frame = '0;
		res.found       = 1'b0;
		res.frame_used  = 1'b0;
		res.free_total  = fba_pkg::COUNT_W'(free_q);
		unique case (state_q)
			S_UPD: begin
				res_valid       = res_room;
				res.frame_used  = used_u;
				res.free_total  = fba_pkg::COUNT_W'(free_next);
			end
			S_FWORD: begin
				res_valid       = res_room;
				res.found       = 1'b1;
				res.found_frame = fba_pkg::FRAME_W'({wi_u, fb});
			end
			S_DONE: begin
				res_valid = res_room;
			end
			S_CLEAR, S_IDLE, S_FSUM: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			top_q   <= '0;
			free_q  <= CNT_W'(FRAME_COUNT);
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WIDX_W'(1);
					if (clr_q == WIDX_W'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (in_mode == fba_pkg::MODE_FIND) begin
							state_q <= top_free ? S_FSUM : S_DONE;
						end else begin
							state_q <= in_ok ? S_UPD : S_DONE;
						end
					end
				end
				S_FSUM: begin
					state_q <= S_FWORD;
				end
				S_UPD: begin
					if (res_room) begin
						state_q <= S_IDLE;
						free_q  <= free_next;
						if (changed_u) begin
							top_q[si_q] <= top_full_u;
						end
					end
				end
				S_FWORD, S_DONE: begin
					if (res_room) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q  <= in_mode;
			frame_q <= FRM_W'(in_frame);
			si_q    <= (in_mode == fba_pkg::MODE_FIND) ? top_si : SIDX_W'(in_wi >> BIT_W);
		end else if (state_q == S_FSUM) begin
			frame_q <= {fz_wi, BIT_W'(0)};
		end
	end

endmodule

### sv/frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// Used/free bitmap of physical page frames with test, mark, release and
// lowest-free search, plus a running free-frame count.
// ----------------------------------------------------------------------------
// After reset the block clears the FRAME_COUNT/WORD_BITS bitmap RAM words
// (2048 at the defaults) and holds s_axis_tready low meanwhile.
// One request is handled at a time. Test, mark and release of a frame in
// range issue the bitmap and summary RAM reads in the accept cycle; the
// update state then writes back and loads the result once the output
// register has room. A find reads the word-full summary RAM in the accept
// cycle and then the bitmap RAM before it loads the result; a find with
// every frame used skips both reads. The next request is accepted the cycle
// after a result enters the output register, even while that result waits
// to be taken, so a request is taken only once the last result is loaded.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
	parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEF,
	parameter int WORD_BITS   = fba_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [fba_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] frame_index
	input  logic [fba_pkg::MODE_W-1:0]       s_axis_tuser,  // [1:0] mode
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [15:0] found_frame, [16] found, [17] frame_used, [34:18] free_total
	output logic [fba_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	logic                              res_valid;
	logic                              res_room;
	fba_pkg::result_t                  res;
	logic                              m_valid_q;
	logic [fba_pkg::OUT_DATA_W-1:0]    m_data_q;

	fba_seq #(.FRAME_COUNT(FRAME_COUNT), .WORD_BITS(WORD_BITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (fba_pkg::mode_t'(s_axis_tuser)),
		.in_frame  (s_axis_tdata),
		.res_valid (res_valid),
		.res       (res),
		.res_room  (res_room)
	);

	// Output register
	assign res_room = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_data_q <= fba_pkg::OUT_DATA_W'(res);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

### sv/fba_checker.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator checker
// Port-level assertions on the allocator stream transactions.
// ----------------------------------------------------------------------------
`include "frame_bitmap_allocator_defines.svh"

module fba_checker #(
	parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [fba_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input logic [fba_pkg::MODE_W-1:0]       s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [fba_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	fba_pkg::result_t beat;

	assign beat = fba_pkg::result_t'(m_axis_tdata[fba_pkg::RESULT_W-1:0]);

	// A stalled result holds
	`FBA_ASSERT_NEXT(a_out_hold, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata)), "result changed while stalled")

	// One request at a time: ready drops after each input transaction
	`FBA_ASSERT_NEXT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready), (!s_axis_tready), "request accepted while busy")

	// A found frame lies in range and reports no prior use
	`FBA_ASSERT_NOW(a_found_frame, (m_axis_tvalid && beat.found), (!beat.frame_used && 32'(beat.found_frame) < 32'(FRAME_COUNT)), "bad search result")

	// Free count never exceeds the frame count
	`FBA_ASSERT_NOW(a_free_bound, m_axis_tvalid, (32'(beat.free_total) <= 32'(FRAME_COUNT)), "free count above frame count")

endmodule

bind frame_bitmap_allocator fba_checker #(.FRAME_COUNT(FRAME_COUNT)) u_fba_checker (.*);
